[hdl/skvt_pkg.sv]
// Shared types and constants of the short key/value table.
package skvt_pkg;

	localparam int ENTRIES_DEF   = 64;
	localparam int KEY_BYTES_DEF = 9;
	localparam int VAL_W         = 32;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DUP  = 2'd1,
		ST_MISS = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	localparam logic [VAL_W-1:0] VAL_NONE = {VAL_W{1'b1}};

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic finish;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
		logic out_free;
	} dp_stat_t;

endpackage

[hdl/skvt_ctrl.sv]
// Controller state machine of the short key/value table.
module skvt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  skvt_pkg::dp_stat_t dstat,
	output skvt_pkg::dp_cmd_t  dcmd
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (dstat.scan_done) state_d = S_FINISH;
			end
			S_FINISH: begin
				// hold until the output register can take the beat
				if (dstat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign dcmd.load   = in_ready && in_valid;
	assign dcmd.scan   = (state_q == S_SCAN);
	assign dcmd.finish = (state_q == S_FINISH) && dstat.out_free;

endmodule

[hdl/skvt_dp.sv]
// Datapath of the short key/value table: key store, scan compare, result register.
module skvt_dp #(
	parameter int ENTRIES   = skvt_pkg::ENTRIES_DEF,
	parameter int KEY_BYTES = skvt_pkg::KEY_BYTES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd,
	input  logic [63:0]                        key_low,
	input  logic [7:0]                         key_high,
	input  logic signed [skvt_pkg::VAL_W-1:0]  value,
	output logic signed [skvt_pkg::VAL_W-1:0]  result_value,
	output logic [1:0]                         status,
	output logic                               out_valid,
	input  logic                               out_ready,
	input  skvt_pkg::dp_cmd_t                  dcmd,
	output skvt_pkg::dp_stat_t                 dstat
);

	localparam int KW = 8 * KEY_BYTES;
	localparam int VW = skvt_pkg::VAL_W;
	localparam int EW = KW + VW;
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	logic [EW-1:0]  mem_q [ENTRIES];
	logic [EW-1:0]  rd_s1;
	logic           rd_pend_s1;

	logic           cmd_q;
	logic [KW-1:0]  key_q;
	logic [VW-1:0]  value_q;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  idx_q;
	logic           hit_q;
	logic [VW-1:0]  hit_val_q;
	logic [VW-1:0]  res_q;
	logic [1:0]     status_q;
	logic           out_valid_q;

	logic [71:0]    key_raw;
	logic [71:0]    key_norm;
	logic [8:0]     keep;
	logic           idx_more;
	logic           match;
	logic           rd_en;
	logic           full;
	logic           wr_en;
	logic [VW-1:0]  res_d;
	logic [1:0]     status_d;

	// a key ends at its first zero byte; bytes past KEY_BYTES are dropped
	assign key_raw = {key_high, key_low};
	always_comb begin
		keep     = '0;
		key_norm = '0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			if (i == 0) begin
				keep[i] = |key_raw[8*i +: 8];
			end else begin
				keep[i] = keep[i-1] && (|key_raw[8*i +: 8]);
			end
			key_norm[8*i +: 8] = keep[i] ? key_raw[8*i +: 8] : 8'h00;
		end
	end

	// entries fill from index zero and never free, so valid means below count
	assign idx_more = (idx_q != count_q);
	assign match    = rd_pend_s1 && (rd_s1[KW-1:0] == key_q);
	assign rd_en    = dcmd.scan && idx_more && !hit_q && !match;
	assign full     = (count_q == CW'(ENTRIES));
	assign wr_en    = dcmd.finish && (cmd_q == skvt_pkg::CMD_INSERT) && !hit_q && !full;

	always_comb begin
		res_d = skvt_pkg::VAL_NONE;
		if (cmd_q == skvt_pkg::CMD_INSERT) begin
			if (hit_q) begin
				status_d = skvt_pkg::ST_DUP;
			end else if (full) begin
				status_d = skvt_pkg::ST_FULL;
			end else begin
				status_d = skvt_pkg::ST_OK;
			end
		end else if (hit_q) begin
			res_d    = hit_val_q;
			status_d = skvt_pkg::ST_OK;
		end else begin
			status_d = skvt_pkg::ST_MISS;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[count_q[AW-1:0]] <= {value_q, key_q};
		if (rd_en) rd_s1 <= mem_q[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (dcmd.load) begin
			cmd_q   <= cmd;
			key_q   <= key_norm[KW-1:0];
			value_q <= value;
		end
		if (dcmd.scan && match) hit_val_q <= rd_s1[EW-1:KW];
		if (dcmd.finish) begin
			res_q    <= res_d;
			status_q <= status_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			rd_pend_s1  <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_s1 <= rd_en;
			if (wr_en) count_q <= count_q + CW'(1);
			if (dcmd.load) begin
				idx_q <= '0;
			end else if (rd_en) begin
				idx_q <= idx_q + CW'(1);
			end
			if (dcmd.load) begin
				hit_q <= 1'b0;
			end else if (dcmd.scan && match) begin
				hit_q <= 1'b1;
			end
			if (dcmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign dstat.scan_done = hit_q || (!idx_more && !rd_pend_s1);
	assign dstat.out_free  = !out_valid_q || out_ready;

	assign result_value = res_q;
	assign status       = status_q;
	assign out_valid    = out_valid_q;

endmodule

[hdl/short_key_value_table.sv]
// Short key/value table: a bounded store of up to ENTRIES key/value pairs.
//
// Input channel (in_valid/in_ready) carries one command per beat: cmd selects
// insert or lookup, key_low/key_high hold a zero padded key of up to nine
// bytes, value is the data stored on insert. Output channel (out_valid/
// out_ready) returns one beat per command: result_value and status.
// A command scans the stored entries in order through one read port of the
// key store, one entry per cycle, and stops at the first match. After the
// scan the command passes through the FINISH state, which registers
// result_value and status and raises out_valid.
// One command is in flight at a time; the next is accepted as soon as the
// result sits in the output register, even while the receiver stalls.
// A finished result waits in the FINISH state only if the output register
// is still full. Reset empties the table at once (fill count to zero) and
// drops any pending result.
module short_key_value_table #(
	parameter int ENTRIES   = skvt_pkg::ENTRIES_DEF,
	parameter int KEY_BYTES = skvt_pkg::KEY_BYTES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               cmd,
	input  logic [63:0]                        key_low,
	input  logic [7:0]                         key_high,
	input  logic signed [skvt_pkg::VAL_W-1:0]  value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [skvt_pkg::VAL_W-1:0]  result_value,
	output logic [1:0]                         status
);

	skvt_pkg::dp_cmd_t  dcmd;
	skvt_pkg::dp_stat_t dstat;

	skvt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.dstat    (dstat),
		.dcmd     (dcmd)
	);

	skvt_dp #(
		.ENTRIES   (ENTRIES),
		.KEY_BYTES (KEY_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.key_low      (key_low),
		.key_high     (key_high),
		.value        (value),
		.result_value (result_value),
		.status       (status),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.dcmd         (dcmd),
		.dstat        (dstat)
	);

endmodule

[hdl/skvt_checker.sv]
// Port-level checks of the short key/value table, bound to the top level.
module skvt_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [skvt_pkg::VAL_W-1:0]  result_value,
	input logic [1:0]                         status
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(result_value) && $stable(status))
		else $error("result beat changed while stalled");

	// the block goes busy right after it takes a command
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second command taken while one is in flight");

	a_neg_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == skvt_pkg::ST_DUP || status == skvt_pkg::ST_MISS
			|| status == skvt_pkg::ST_FULL) |-> result_value == skvt_pkg::VAL_NONE)
		else $error("non-ok status with a value other than -1");

	a_value_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_value != skvt_pkg::VAL_NONE |-> status == skvt_pkg::ST_OK)
		else $error("stored value returned with a non-ok status");

endmodule

bind short_key_value_table skvt_checker u_skvt_checker (.*);

[tb/sv/short_key_value_table_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for the short key/value table: directed and random inserts and lookups.
module short_key_value_table_test;

	localparam int SLOTS        = skvt_pkg::ENTRIES_DEF;
	localparam int KEY_LEN      = skvt_pkg::KEY_BYTES_DEF;
	localparam int POOL_KEYS    = 96;
	localparam int RAND_BEATS   = 1080;
	localparam int CALM_TAIL    = 150;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 100;
	localparam int PRINT_CAP    = 100;

	typedef struct {
		logic               op;
		logic [63:0]        lo;
		logic [7:0]         hi;
		logic signed [31:0] val;
		bit                 drain;
	} cmd_beat_t;

	typedef struct packed {
		logic signed [31:0] data;
		skvt_pkg::status_t  code;
	} reply_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               in_valid     = 1'b0;
	logic               in_ready;
	logic               cmd          = skvt_pkg::CMD_INSERT;
	logic [63:0]        key_low      = '0;
	logic [7:0]         key_high     = '0;
	logic signed [31:0] value        = '0;
	logic               out_valid;
	logic               out_ready    = 1'b0;
	logic signed [31:0] result_value;
	logic [1:0]         status;

	cmd_beat_t   beats_to_send[$];
	reply_t      replies_due[$];
	logic [71:0] key_pool[POOL_KEYS];

	// behavioral copy of the store
	logic [71:0]        slot_key[SLOTS];
	logic signed [31:0] slot_value[SLOTS];
	bit                 slot_used[SLOTS];

	bit in_took     = 1'b0;
	int send_gap    = 0;
	int stall_left  = 0;
	int idle_cycles = 0;
	int errors      = 0;

	short_key_value_table dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.key_low      (key_low),
		.key_high     (key_high),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.status       (status)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= PRINT_CAP)
			$display("mismatch at %0t: %s", $time, what);
	endtask

	// Cut the key at its first zero byte and at the key length.
	function automatic logic [71:0] trim_key(input logic [63:0] lo, input logic [7:0] hi);
		logic [71:0] raw;
		logic [71:0] kept;
		bit          ended;
		int          i;
		raw   = {hi, lo};
		kept  = '0;
		ended = 1'b0;
		for (i = 0; i < KEY_LEN; i++) begin
			if (raw[8*i +: 8] == 8'h00)
				ended = 1'b1;
			if (!ended)
				kept[8*i +: 8] = raw[8*i +: 8];
		end
		return kept;
	endfunction

	function automatic reply_t store_apply(input logic op, input logic [63:0] lo,
			input logic [7:0] hi, input logic signed [31:0] val);
		reply_t      r;
		logic [71:0] k;
		int          hit;
		int          slot;
		int          i;
		k    = trim_key(lo, hi);
		hit  = -1;
		slot = -1;
		for (i = 0; i < SLOTS; i++) begin
			if (slot_used[i]) begin
				if (hit < 0 && slot_key[i] == k)
					hit = i;
			end else if (slot < 0) begin
				slot = i;
			end
		end
		r.data = skvt_pkg::VAL_NONE;
		if (op == skvt_pkg::CMD_INSERT) begin
			if (hit >= 0) begin
				r.code = skvt_pkg::ST_DUP;
			end else if (slot < 0) begin
				r.code = skvt_pkg::ST_FULL;
			end else begin
				slot_key[slot]   = k;
				slot_value[slot] = val;
				slot_used[slot]  = 1'b1;
				r.code           = skvt_pkg::ST_OK;
			end
		end else if (hit >= 0) begin
			r.data = slot_value[hit];
			r.code = skvt_pkg::ST_OK;
		end else begin
			r.code = skvt_pkg::ST_MISS;
		end
		return r;
	endfunction

	function automatic logic [71:0] fresh_key();
		logic [71:0] k;
		int          n;
		int          i;
		k = '0;
		n = $urandom_range(1, KEY_LEN);
		for (i = 0; i < n; i++)
			k[8*i +: 8] = 8'($urandom_range(1, 255));
		return k;
	endfunction

	// Fill the bytes past the terminating zero with junk now and then.
	function automatic logic [71:0] dress_key(input logic [71:0] k);
		logic [71:0] d;
		bit          past_end;
		int          i;
		d        = k;
		past_end = 1'b0;
		if ($urandom_range(0, 2) == 0) begin
			for (i = 0; i < KEY_LEN; i++) begin
				if (past_end)
					d[8*i +: 8] = 8'($urandom_range(0, 255));
				else if (k[8*i +: 8] == 8'h00)
					past_end = 1'b1;
			end
		end
		return d;
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: begin
				return 32'sh8000_0000;
			end
			1: begin
				return 32'sh7FFF_FFFF;
			end
			2: begin
				return -32'sd1;
			end
			3: begin
				return 32'sd0;
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	task automatic queue_beat(input logic op, input logic [63:0] lo, input logic [7:0] hi,
			input logic signed [31:0] val, input bit drain);
		cmd_beat_t b;
		b.op    = op;
		b.lo    = lo;
		b.hi    = hi;
		b.val   = val;
		b.drain = drain;
		beats_to_send.push_back(b);
	endtask

	// Input driver: hold the beat until accepted, then advance or idle.
	always @(negedge clk) begin : drive_commands
		cmd_beat_t b;
		if (arst_n && !(in_valid && !in_took)) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (beats_to_send.size() != 0 &&
					!(beats_to_send[0].drain && replies_due.size() != 0)) begin
				b = beats_to_send.pop_front();
				cmd      <= b.op;
				key_low  <= b.lo;
				key_high <= b.hi;
				value    <= b.val;
				in_valid <= 1'b1;
				if (beats_to_send.size() >= CALM_TAIL && $urandom_range(0, 5) == 0)
					send_gap = $urandom_range(1, 11);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (beats_to_send.size() >= CALM_TAIL && $urandom_range(0, 4) == 0)
				stall_left = $urandom_range(1, 11);
		end
	end

	always @(posedge clk) begin : check_replies
		reply_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (replies_due.size() == 0) begin
					report_mismatch($sformatf("result with nothing pending: value %0d status %0d",
						result_value, status));
				end else begin
					want = replies_due.pop_front();
					if (result_value !== want.data)
						report_mismatch($sformatf("result_value %0d, want %0d",
							result_value, want.data));
					if (status !== want.code)
						report_mismatch($sformatf("status %0d, want %0d", status, want.code));
				end
			end
			if (in_valid && in_ready)
				replies_due.push_back(store_apply(cmd, key_low, key_high, value));
			in_took <= in_valid && in_ready;
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT) begin
			$display("short_key_value_table verification failed");
			$finish;
		end
	end

	initial begin : run
		logic [71:0] k;
		logic        op;
		int          n;
		int          pick;
		for (n = 0; n < POOL_KEYS; n++)
			key_pool[n] = fresh_key();

		// empty key, with and without junk behind the leading zero
		queue_beat(skvt_pkg::CMD_LOOKUP, 64'h0, 8'h00, 32'sd0, 1'b0);
		queue_beat(skvt_pkg::CMD_INSERT, 64'h0, 8'h00, 32'sh7FFF_FFFF, 1'b0);
		queue_beat(skvt_pkg::CMD_INSERT, 64'hFFFF_FFFF_FFFF_FF00, 8'hFF, 32'sd5, 1'b0);
		queue_beat(skvt_pkg::CMD_LOOKUP, 64'h8000_0000_0000_0000, 8'h80, 32'sd0, 1'b0);
		// one-byte key, duplicate, lookup with bytes after the terminator
		queue_beat(skvt_pkg::CMD_INSERT, 64'h41, 8'h00, 32'sh8000_0000, 1'b0);
		queue_beat(skvt_pkg::CMD_INSERT, 64'h41, 8'h00, 32'sd7, 1'b0);
		queue_beat(skvt_pkg::CMD_LOOKUP, 64'h0000_0000_ABCD_0041, 8'h00, 32'sd0, 1'b0);
		queue_beat(skvt_pkg::CMD_LOOKUP, 64'h41, 8'h41, 32'sd0, 1'b0);
		// full-length keys that differ only in the last byte, then their eight-byte prefix
		queue_beat(skvt_pkg::CMD_INSERT, '1, 8'hFF, -32'sd1, 1'b0);
		queue_beat(skvt_pkg::CMD_INSERT, '1, 8'h01, 32'sd1, 1'b0);
		queue_beat(skvt_pkg::CMD_LOOKUP, '1, 8'hFF, 32'sd0, 1'b0);
		queue_beat(skvt_pkg::CMD_LOOKUP, '1, 8'h01, 32'sd0, 1'b0);
		queue_beat(skvt_pkg::CMD_LOOKUP, '1, 8'h00, 32'sd0, 1'b0);
		queue_beat(skvt_pkg::CMD_INSERT, '1, 8'h00, 32'sd0, 1'b0);
		queue_beat(skvt_pkg::CMD_LOOKUP, '1, 8'h00, 32'sh1234, 1'b0);
		// zero byte inside the key, then a full-length key with no zero byte
		queue_beat(skvt_pkg::CMD_INSERT, 64'h1122_3344_0055_6677, 8'h88, 32'sh1234_5678,
			1'b0);
		queue_beat(skvt_pkg::CMD_LOOKUP, 64'h0055_6677, 8'h00, 32'sd0, 1'b0);
		queue_beat(skvt_pkg::CMD_INSERT, 64'h0055_6677, 8'h99, 32'sd3, 1'b0);
		queue_beat(skvt_pkg::CMD_LOOKUP, 64'h0101_0101_0101_0101, 8'h01, 32'sd0, 1'b0);
		queue_beat(skvt_pkg::CMD_INSERT, 64'h7F80_0102_0304_0506, 8'hFE, 32'sd1, 1'b0);
		queue_beat(skvt_pkg::CMD_LOOKUP, 64'h7F80_0102_0304_0506, 8'hFE, 32'sd0, 1'b0);

		// Pool keys outnumber the slots, so the store fills and stays full.
		for (n = 0; n < RAND_BEATS; n++) begin
			pick = $urandom_range(0, 19);
			if (pick < 11) begin
				op = skvt_pkg::CMD_INSERT;
				k  = dress_key(key_pool[$urandom_range(0, POOL_KEYS - 1)]);
			end else if (pick < 18) begin
				op = skvt_pkg::CMD_LOOKUP;
				k  = dress_key(key_pool[$urandom_range(0, POOL_KEYS - 1)]);
			end else begin
				op = $urandom_range(0, 1) ? skvt_pkg::CMD_LOOKUP : skvt_pkg::CMD_INSERT;
				k  = {8'($urandom_range(0, 255)), 32'($urandom), 32'($urandom)};
			end
			queue_beat(op, k[63:0], k[71:64], pick_value(),
				n == RAND_BEATS / 3 || n == 2 * RAND_BEATS / 3);
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (beats_to_send.size() != 0 || in_valid)
			@(posedge clk);
		while (replies_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("short_key_value_table verification clean");
		else
			$display("short_key_value_table verification failed");
		$finish;
	end

endmodule

[filelist.f]
hdl/skvt_pkg.sv
hdl/skvt_ctrl.sv
hdl/skvt_dp.sv
hdl/short_key_value_table.sv
hdl/skvt_checker.sv
tb/sv/short_key_value_table_test.sv
